>>> rtl/mqcb_pkg.sv
// Package with the types, codes and sizes shared by the chunk buffer modules.
`timescale 1ns / 1ps
`default_nettype none
package mqcb_pkg;
   localparam int QueueCount    = 64;
   localparam int QidW          = 6;
   localparam int ChunkCount    = 32;
   localparam int ChunkW        = 5;
   localparam int BytesPerChunk = 64;
   localparam int OffsW         = 6;
   localparam int CountW        = 12;
   localparam int FreeW         = 6;
   localparam int CreatedW      = 7;
   localparam int ByteAddrW     = ChunkW + OffsW;
   localparam int ByteDepth     = ChunkCount * BytesPerChunk;

   typedef enum logic [1:0] {
      REQ_CREATE  = 2'd0,
      REQ_DESTROY = 2'd1,
      REQ_ENQUEUE = 2'd2,
      REQ_DEQUEUE = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_OOM     = 2'd1,
      STAT_ILLEGAL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DEQ
   } state_type;

   typedef struct packed {
      logic [ChunkW-1:0] first;
      logic [ChunkW-1:0] last;
      logic [CountW-1:0] count;
      logic [OffsW-1:0]  rpos;
   } meta_type;

   localparam int MetaW = $bits(meta_type);
endpackage
`default_nettype wire

>>> rtl/mqcb_ram.sv
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module mqcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end
endmodule
`default_nettype wire

>>> rtl/multi_queue_chunk_buffer_unit.sv
// Top level of the multi-queue byte buffer built over a shared chunk store.
//
// A request is presented on req_type, req_queue_id and req_data_byte and is
// taken when start is high while busy is low. The four requests are create,
// destroy, enqueue and dequeue. Every request gives exactly one result on
// rsp_status, rsp_queue_handle and rsp_read_byte, shown for one cycle with
// rsp_valid high; the receiver cannot hold it off.
// When start is taken in idle, the queue record and the free-list link are read
// from their memories; the execute state then checks and writes back. A dequeue
// that succeeds reads the chunk byte and the head link in the execute state and
// writes back in the dequeue state. The result appears in the cycle after the
// last of these. Busy is high in the execute and dequeue states, so no new start
// is taken before a request is through with the single-port metadata and link
// memories. Reset puts the free list in chunk order, marks every queue unused
// and returns to idle; the byte store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module multi_queue_chunk_buffer_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_type,
   input  wire logic [5:0] req_queue_id,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   output logic [1:0]      rsp_status,
   output logic [5:0]      rsp_queue_handle,
   output logic [7:0]      rsp_read_byte
);
   mqcb_pkg::state_type                     state_ff, state_in;
   logic [1:0]                              req_ff;
   logic [mqcb_pkg::QidW-1:0]               qid_ff;
   logic [7:0]                              data_ff;
   logic [mqcb_pkg::ChunkW-1:0]             free_head_ff, free_head_in;
   logic [mqcb_pkg::FreeW-1:0]              free_count_ff, free_count_in;
   logic [mqcb_pkg::CreatedW-1:0]           created_ff, created_in;
   logic [mqcb_pkg::QueueCount-1:0]         live_ff, live_in;
   logic [mqcb_pkg::ChunkCount-1:0]         lvalid_ff, lvalid_in;
   logic [mqcb_pkg::ChunkW-1:0]             laddr_ff;
   mqcb_pkg::meta_type                      meta_ff, meta_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]                              rsp_status_ff, rsp_status_in;
   logic [5:0]                              rsp_handle_ff, rsp_handle_in;
   logic [7:0]                              rsp_byte_ff, rsp_byte_in;

   logic                                    meta_en, meta_we;
   logic [mqcb_pkg::QidW-1:0]               meta_addr;
   mqcb_pkg::meta_type                      meta_wdata, meta_q;
   logic [mqcb_pkg::MetaW-1:0]              meta_rraw;
   logic                                    link_en, link_we;
   logic [mqcb_pkg::ChunkW-1:0]             link_addr, link_wdata, link_q, link_rd;
   logic                                    byte_en, byte_we;
   logic [mqcb_pkg::ByteAddrW-1:0]          byte_addr;
   logic [7:0]                              byte_wdata, byte_q;
   logic                                    deq_go;

   logic [mqcb_pkg::CountW-1:0]             pos;
   logic [mqcb_pkg::CountW:0]               pos_up;
   logic [mqcb_pkg::FreeW-1:0]              n_chunks;
   logic                                    need;
   logic [mqcb_pkg::ChunkW-1:0]             tail;
   logic [mqcb_pkg::CountW-1:0]             cnt_dec;
   logic [mqcb_pkg::OffsW:0]                rp_inc;

   assign meta_q  = mqcb_pkg::meta_type'(meta_rraw);
   assign link_rd = lvalid_ff[laddr_ff] ? link_q : laddr_ff + mqcb_pkg::ChunkW'(1);

   mqcb_ram #(.WIDTH(mqcb_pkg::MetaW), .DEPTH(mqcb_pkg::QueueCount)) u_meta (
      .clock(clock), .en(meta_en), .we(meta_we), .addr(meta_addr),
      .wdata(meta_wdata), .rdata(meta_rraw)
   );

   mqcb_ram #(.WIDTH(mqcb_pkg::ChunkW), .DEPTH(mqcb_pkg::ChunkCount)) u_link (
      .clock(clock), .en(link_en), .we(link_we), .addr(link_addr),
      .wdata(link_wdata), .rdata(link_q)
   );

   mqcb_ram #(.WIDTH(8), .DEPTH(mqcb_pkg::ByteDepth)) u_bytes (
      .clock(clock), .en(byte_en), .we(byte_we), .addr(byte_addr),
      .wdata(byte_wdata), .rdata(byte_q)
   );

   always_comb begin
      pos      = meta_q.rpos + meta_q.count;
      pos_up   = {1'b0, pos} + (mqcb_pkg::CountW+1)'(mqcb_pkg::BytesPerChunk - 1);
      n_chunks = (pos == '0) ? mqcb_pkg::FreeW'(1) : pos_up[mqcb_pkg::FreeW+5:6];
      need     = (pos != '0) && (pos[mqcb_pkg::OffsW-1:0] == '0);
      tail     = need ? free_head_ff : meta_q.last;
      cnt_dec  = meta_ff.count - mqcb_pkg::CountW'(1);
      rp_inc   = {1'b0, meta_ff.rpos} + (mqcb_pkg::OffsW+1)'(1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mqcb_pkg::S_IDLE: begin
            if (start) begin
               state_in = mqcb_pkg::S_EXEC;
            end
         end
         mqcb_pkg::S_EXEC: begin
            state_in = deq_go ? mqcb_pkg::S_DEQ : mqcb_pkg::S_IDLE;
         end
         mqcb_pkg::S_DEQ: begin
            state_in = mqcb_pkg::S_IDLE;
         end
         default: begin
            state_in = mqcb_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy          = (state_ff != mqcb_pkg::S_IDLE);
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      created_in    = created_ff;
      live_in       = live_ff;
      lvalid_in     = lvalid_ff;
      meta_in       = meta_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_byte_in   = rsp_byte_ff;
      meta_en       = 1'b0;
      meta_we       = 1'b0;
      meta_addr     = qid_ff;
      meta_wdata    = meta_q;
      link_en       = 1'b0;
      link_we       = 1'b0;
      link_addr     = free_head_ff;
      link_wdata    = free_head_ff;
      byte_en       = 1'b0;
      byte_we       = 1'b0;
      byte_addr     = {tail, pos[mqcb_pkg::OffsW-1:0]};
      byte_wdata    = data_ff;
      deq_go        = 1'b0;
      unique case (state_ff)
         mqcb_pkg::S_IDLE: begin
            meta_en   = start;
            meta_addr = req_queue_id;
            link_en   = start;
         end
         mqcb_pkg::S_EXEC: begin
            meta_in       = meta_q;
            rsp_valid_in  = 1'b1;
            rsp_status_in = mqcb_pkg::STAT_OK;
            rsp_handle_in = qid_ff;
            rsp_byte_in   = '0;
            if (req_ff == mqcb_pkg::REQ_CREATE) begin
               if (created_ff >= mqcb_pkg::CreatedW'(mqcb_pkg::QueueCount) ||
                   free_count_ff == '0) begin
                  rsp_status_in = mqcb_pkg::STAT_OOM;
                  rsp_handle_in = '0;
               end else begin
                  meta_en       = 1'b1;
                  meta_we       = 1'b1;
                  meta_addr     = created_ff[mqcb_pkg::QidW-1:0];
                  meta_wdata    = '{first: free_head_ff, last: free_head_ff,
                                    count: '0, rpos: '0};
                  live_in[created_ff[mqcb_pkg::QidW-1:0]] = 1'b1;
                  created_in    = created_ff + mqcb_pkg::CreatedW'(1);
                  rsp_handle_in = created_ff[mqcb_pkg::QidW-1:0];
                  free_head_in  = link_rd;
                  free_count_in = free_count_ff - mqcb_pkg::FreeW'(1);
               end
            end else if (!live_ff[qid_ff]) begin
               rsp_status_in = mqcb_pkg::STAT_ILLEGAL;
            end else if (req_ff == mqcb_pkg::REQ_DESTROY) begin
               link_en            = 1'b1;
               link_we            = 1'b1;
               link_addr          = meta_q.last;
               lvalid_in[meta_q.last] = 1'b1;
               free_head_in       = meta_q.first;
               free_count_in      = free_count_ff + n_chunks;
               live_in[qid_ff]    = 1'b0;
            end else if (req_ff == mqcb_pkg::REQ_ENQUEUE) begin
               if (need && free_count_ff == '0) begin
                  rsp_status_in = mqcb_pkg::STAT_OOM;
               end else begin
                  byte_en          = 1'b1;
                  byte_we          = 1'b1;
                  meta_en          = 1'b1;
                  meta_we          = 1'b1;
                  meta_wdata.count = meta_q.count + mqcb_pkg::CountW'(1);
                  if (need) begin
                     link_en                = 1'b1;
                     link_we                = 1'b1;
                     link_addr              = meta_q.last;
                     lvalid_in[meta_q.last] = 1'b1;
                     meta_wdata.last        = free_head_ff;
                     free_head_in           = link_rd;
                     free_count_in          = free_count_ff - mqcb_pkg::FreeW'(1);
                  end
               end
            end else if (meta_q.count == '0) begin
               rsp_status_in = mqcb_pkg::STAT_ILLEGAL;
            end else begin
               deq_go       = 1'b1;
               rsp_valid_in = 1'b0;
               byte_en      = 1'b1;
               byte_addr    = {meta_q.first, meta_q.rpos};
               link_en      = 1'b1;
               link_addr    = meta_q.first;
            end
         end
         mqcb_pkg::S_DEQ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = mqcb_pkg::STAT_OK;
            rsp_handle_in = qid_ff;
            rsp_byte_in   = byte_q;
            meta_en       = 1'b1;
            meta_we       = 1'b1;
            meta_wdata    = meta_ff;
            meta_wdata.count = cnt_dec;
            meta_wdata.rpos  = rp_inc[mqcb_pkg::OffsW-1:0];
            if (cnt_dec == '0) begin
               meta_wdata.rpos = '0;
            end else if (rp_inc[mqcb_pkg::OffsW]) begin
               link_en                 = 1'b1;
               link_we                 = 1'b1;
               link_addr               = meta_ff.first;
               lvalid_in[meta_ff.first] = 1'b1;
               free_head_in            = meta_ff.first;
               free_count_in           = free_count_ff + mqcb_pkg::FreeW'(1);
               meta_wdata.first        = link_rd;
               meta_wdata.rpos         = '0;
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mqcb_pkg::S_IDLE;
         free_head_ff  <= '0;
         free_count_ff <= mqcb_pkg::FreeW'(mqcb_pkg::ChunkCount);
         created_ff    <= '0;
         live_ff       <= '0;
         lvalid_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         created_ff    <= created_in;
         live_ff       <= live_in;
         lvalid_ff     <= lvalid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff  <= req_type;
         qid_ff  <= req_queue_id;
         data_ff <= req_data_byte;
      end
      if (link_en && !link_we) begin
         laddr_ff <= link_addr;
      end
      meta_ff       <= meta_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_queue_handle = rsp_handle_ff;
   assign rsp_read_byte    = rsp_byte_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= mqcb_pkg::FreeW'(mqcb_pkg::ChunkCount))
      else $error("free chunk count exceeds the store size");

   a_created_bound: assert property (@(posedge clock) disable iff (reset)
      created_ff <= mqcb_pkg::CreatedW'(mqcb_pkg::QueueCount))
      else $error("created queue count exceeds the queue limit");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == mqcb_pkg::S_EXEC ||
                        $past(state_ff) == mqcb_pkg::S_DEQ))
      else $error("result shown without a transaction in progress");

   a_deq_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == mqcb_pkg::S_DEQ |=> rsp_valid_ff)
      else $error("dequeue finished without a result");
endmodule
`default_nettype wire

>>> verif/tb_multi_queue_chunk_buffer_unit.sv
// Self-checking testbench for the multi-queue chunk buffer unit.
`timescale 1ns / 1ps
module tb_multi_queue_chunk_buffer_unit;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_type = mqcb_pkg::REQ_CREATE;
   logic [5:0] req_queue_id = '0;
   logic [7:0] req_data_byte = '0;
   logic       rsp_valid;
   logic [1:0] rsp_status;
   logic [5:0] rsp_queue_handle;
   logic [7:0] rsp_read_byte;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] handle;
      logic [7:0] rdata;
   } outcome_type;

   localparam int LifeUnused = 0;
   localparam int LifeLive   = 1;
   localparam int LifeDead   = 2;
   localparam int StallLimit = 2000;

   outcome_type expected_outcomes[$];
   bit          failed = 1'b0;
   int          idle_cycles = 0;

   logic [7:0] m_bytes[mqcb_pkg::ByteDepth];
   logic [4:0] m_link[mqcb_pkg::ChunkCount];
   logic [4:0] m_free_head;
   int         m_free_count;
   logic [4:0] m_first[mqcb_pkg::QueueCount];
   logic [4:0] m_last[mqcb_pkg::QueueCount];
   int         m_count[mqcb_pkg::QueueCount];
   int         m_rpos[mqcb_pkg::QueueCount];
   int         m_life[mqcb_pkg::QueueCount];
   int         m_created;

   multi_queue_chunk_buffer_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_queue_id(req_queue_id), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_queue_handle(rsp_queue_handle), .rsp_read_byte(rsp_read_byte)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [4:0] take_free_chunk();
      logic [4:0] c;
      c = m_free_head;
      m_free_head = m_link[c];
      m_free_count--;
      return c;
   endfunction

   function automatic outcome_type predict_outcome(mqcb_pkg::req_code_type op,
                                                   logic [5:0] qid, logic [7:0] din);
      outcome_type o;
      int pos;
      int n;
      int rp;
      bit need;
      logic [4:0] c;
      logic [4:0] tail;
      logic [4:0] head;
      o = '{status: mqcb_pkg::STAT_OK, handle: qid, rdata: 8'd0};
      if (op == mqcb_pkg::REQ_CREATE) begin
         if (m_created >= mqcb_pkg::QueueCount || m_free_count == 0) begin
            o.status = mqcb_pkg::STAT_OOM;
            o.handle = '0;
         end else begin
            c = take_free_chunk();
            m_first[m_created] = c;
            m_last[m_created] = c;
            m_count[m_created] = 0;
            m_rpos[m_created] = 0;
            m_life[m_created] = LifeLive;
            o.handle = 6'(m_created);
            m_created++;
         end
      end else if (m_life[qid] != LifeLive) begin
         o.status = mqcb_pkg::STAT_ILLEGAL;
      end else begin
         pos = m_rpos[qid] + m_count[qid];
         if (op == mqcb_pkg::REQ_DESTROY) begin
            n = (pos + mqcb_pkg::BytesPerChunk - 1) / mqcb_pkg::BytesPerChunk;
            if (n == 0) n = 1;
            m_link[m_last[qid]] = m_free_head;
            m_free_head = m_first[qid];
            m_free_count += n;
            m_life[qid] = LifeDead;
         end else if (op == mqcb_pkg::REQ_ENQUEUE) begin
            need = pos > 0 && pos % mqcb_pkg::BytesPerChunk == 0;
            if (need && m_free_count == 0) begin
               o.status = mqcb_pkg::STAT_OOM;
            end else begin
               tail = m_last[qid];
               if (need) begin
                  c = take_free_chunk();
                  m_link[tail] = c;
                  m_last[qid] = c;
                  tail = c;
               end
               m_bytes[tail * mqcb_pkg::BytesPerChunk + pos % mqcb_pkg::BytesPerChunk] = din;
               m_count[qid]++;
            end
         end else begin
            if (m_count[qid] == 0) begin
               o.status = mqcb_pkg::STAT_ILLEGAL;
            end else begin
               head = m_first[qid];
               rp = m_rpos[qid] % mqcb_pkg::BytesPerChunk;
               o.rdata = m_bytes[head * mqcb_pkg::BytesPerChunk + rp];
               m_count[qid]--;
               rp++;
               if (m_count[qid] == 0) begin
                  rp = 0;
               end else if (rp >= mqcb_pkg::BytesPerChunk) begin
                  m_first[qid] = m_link[head];
                  m_link[head] = m_free_head;
                  m_free_head = head;
                  m_free_count++;
                  rp = 0;
               end
               m_rpos[qid] = rp;
            end
         end
      end
      return o;
   endfunction

   // After a transaction is taken the block is busy, so start may stay high until the
   // next request or the next pause lowers it.
   task automatic issue_request(mqcb_pkg::req_code_type op, logic [5:0] qid,
                                logic [7:0] din, bit gaps = 1'b1);
      int gap;
      gap = gaps ? $urandom_range(0, 16) : 0;
      if ((gaps && $urandom_range(0, 3) == 0) || gap == 0) begin
         gap = 0;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type <= op;
      req_queue_id <= qid;
      req_data_byte <= din;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_outcomes.push_back(predict_outcome(op, qid, din));
      @(negedge clock);
   endtask

   task automatic drain_outcomes();
      start <= 1'b0;
      while (expected_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if (rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            $error("Unexpected transaction on the result port");
            failed = 1'b1;
         end else begin
            e = expected_outcomes.pop_front();
            if (rsp_status !== e.status) begin
               $error("rsp_status: expected %0d, actual %0d", e.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_queue_handle !== e.handle) begin
               $error("rsp_queue_handle: expected %0d, actual %0d", e.handle,
                      rsp_queue_handle);
               failed = 1'b1;
            end
            if (rsp_read_byte !== e.rdata) begin
               $error("rsp_read_byte: expected %0d, actual %0d", e.rdata, rsp_read_byte);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic test_directed();
      issue_request(mqcb_pkg::REQ_DESTROY, 6'd63, 8'hFF);
      issue_request(mqcb_pkg::REQ_ENQUEUE, 6'd0, 8'h00);
      issue_request(mqcb_pkg::REQ_DEQUEUE, 6'd5, 8'h00);
      issue_request(mqcb_pkg::REQ_CREATE, 6'd63, 8'hFF);
      issue_request(mqcb_pkg::REQ_DEQUEUE, 6'd0, 8'h00);
      issue_request(mqcb_pkg::REQ_ENQUEUE, 6'd0, 8'hFF);
      issue_request(mqcb_pkg::REQ_ENQUEUE, 6'd0, 8'h00);
      issue_request(mqcb_pkg::REQ_ENQUEUE, 6'd0, 8'hA5);
      issue_request(mqcb_pkg::REQ_DEQUEUE, 6'd0, 8'h00);
      issue_request(mqcb_pkg::REQ_DEQUEUE, 6'd0, 8'h00);
      issue_request(mqcb_pkg::REQ_DEQUEUE, 6'd0, 8'h00);
      issue_request(mqcb_pkg::REQ_DEQUEUE, 6'd0, 8'h00);
      issue_request(mqcb_pkg::REQ_ENQUEUE, 6'd0, 8'h5A);
      issue_request(mqcb_pkg::REQ_CREATE, 6'd0, 8'h00);
      issue_request(mqcb_pkg::REQ_DESTROY, 6'd1, 8'h00);
      issue_request(mqcb_pkg::REQ_ENQUEUE, 6'd1, 8'h11);
      issue_request(mqcb_pkg::REQ_DESTROY, 6'd1, 8'h00);
      issue_request(mqcb_pkg::REQ_DEQUEUE, 6'd0, 8'h00);
   endtask

   task automatic test_chunk_chaining();
      int i;
      for (i = 0; i < 150; i++) begin
         issue_request(mqcb_pkg::REQ_ENQUEUE, 6'd0, 8'($urandom_range(0, 255)), i % 8 == 0);
      end
      for (i = 0; i < 140; i++) begin
         issue_request(mqcb_pkg::REQ_DEQUEUE, 6'd0, 8'h00, i % 8 == 0);
      end
      drain_outcomes();
   endtask

   task automatic test_out_of_memory();
      int i;
      for (i = 0; i < 31; i++) issue_request(mqcb_pkg::REQ_CREATE, 6'd0, 8'h00, 1'b0);
      issue_request(mqcb_pkg::REQ_ENQUEUE, 6'd0, 8'h77, 1'b0);
      for (i = 0; i < 64; i++) issue_request(mqcb_pkg::REQ_ENQUEUE, 6'd3, 8'h00, 1'b0);
      issue_request(mqcb_pkg::REQ_DESTROY, 6'd4, 8'h00);
      issue_request(mqcb_pkg::REQ_DESTROY, 6'd5, 8'h00);
      drain_outcomes();
   endtask

   task automatic test_random_traffic();
      int i;
      int k;
      logic [5:0] qid;
      mqcb_pkg::req_code_type op;
      for (i = 0; i < 200; i++) begin
         k = $urandom_range(0, 99);
         qid = (k < 90 && m_created > 0) ? 6'($urandom_range(0, m_created - 1))
                                         : 6'($urandom_range(0, 63));
         if (k < 3) op = mqcb_pkg::REQ_CREATE;
         else if (k < 7) op = mqcb_pkg::REQ_DESTROY;
         else if (k < 55) op = mqcb_pkg::REQ_ENQUEUE;
         else op = mqcb_pkg::REQ_DEQUEUE;
         issue_request(op, qid, 8'($urandom_range(0, 255)));
      end
      for (i = 0; i < 40; i++) begin
         issue_request(mqcb_pkg::REQ_CREATE, 6'($urandom_range(0, 63)), 8'h00);
      end
      for (i = 0; i < 20; i++) begin
         issue_request(mqcb_pkg::REQ_DESTROY, 6'($urandom_range(0, 63)), 8'h00);
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < mqcb_pkg::ChunkCount; i++) begin
         m_link[i] = 5'((i + 1) % mqcb_pkg::ChunkCount);
      end
      for (i = 0; i < mqcb_pkg::QueueCount; i++) begin
         m_life[i] = LifeUnused;
         m_first[i] = '0;
         m_last[i] = '0;
         m_count[i] = 0;
         m_rpos[i] = 0;
      end
      m_free_head = '0;
      m_free_count = mqcb_pkg::ChunkCount;
      m_created = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_chunk_chaining();
      test_out_of_memory();
      test_random_traffic();
      drain_outcomes();
      if (!failed) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

>>> filelist.f
rtl/mqcb_pkg.sv
rtl/mqcb_ram.sv
rtl/multi_queue_chunk_buffer_unit.sv
verif/tb_multi_queue_chunk_buffer_unit.sv
